@@ sv/lzwc_pkg.sv @@
package lzwc_pkg;

  localparam int MinCodeBits = 9;
  localparam int MaxCodeBits = 12;
  localparam int HashSlots   = 8192;

  localparam int CODE_W = MaxCodeBits;
  localparam int KEY_W  = CODE_W + 8;
  localparam int SLOT_W = $clog2(HashSlots);
  localparam int WID_W  = $clog2(MaxCodeBits + 1);
  localparam int ACC_W  = CODE_W + 7;
  localparam int CNT_W  = $clog2(ACC_W + 1);

  localparam logic [CODE_W-1:0] CODE_CLEAR = CODE_W'(256);
  localparam logic [CODE_W-1:0] CODE_END   = CODE_W'(257);
  localparam logic [CODE_W-1:0] CODE_START = CODE_W'(258);
  localparam logic [CODE_W-1:0] CODE_LIMIT = CODE_W'((1 << MaxCodeBits) - 3);
  localparam logic [WID_W-1:0]  WIDTH_MIN  = WID_W'(MinCodeBits);

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } dict_entry_t;

  localparam int ENTRY_W = $bits(dict_entry_t);

endpackage

@@ sv/lzw_compressor_variable_width.sv @@
// The opening clear code goes to the output first; each data byte is then looked up
// by hash probes, and on a miss the prefix code is packed into output bytes.
// Bytes are taken one at a time, paced by the probe loop on the single dictionary RAM.
// Reset (rst_n low, synchronous) clears control state, then a clearing pass
// sweeps all 8192 dictionary slots; the same pass follows a table-full restart
// and the end of every stream, with in_ready held low.
module lzw_compressor_variable_width (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import lzwc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_RD, S_CMP, S_AFTER, S_RESTART,
    S_TAIL, S_END, S_PAD, S_PUT, S_DRAIN
  } state_t;

  state_t              state_r, ret_r, clr_ret_r;
  logic [SLOT_W-1:0]   clr_addr_r, slot_r;
  logic [7:0]          byte_r;
  logic                last_r, pvalid_r, started_r, fin_r;
  logic [CODE_W-1:0]   prefix_r, next_r, put_code_r;
  logic [WID_W-1:0]    width_r;
  logic [ACC_W-1:0]    acc_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r, out_last_r;
  logic [7:0]          out_byte_r;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  dict_entry_t         ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    key;
  logic [31:0]         prod;
  logic [CODE_W-1:0]   code_mask;
  logic [CODE_W:0]     next_inc;
  logic [ACC_W-1:0]    drain_word, pad_word;
  logic                out_free;
  logic                out_load;

  assign key       = {prefix_r, byte_r};
  assign prod      = 32'(key) * HASH_MULT;
  assign code_mask = CODE_W'((1 << width_r) - 1);
  assign next_inc  = (CODE_W + 1)'(next_r) + (CODE_W + 1)'(1);
  assign drain_word = acc_r >> (cnt_r - CNT_W'(8));
  assign pad_word   = acc_r << (CNT_W'(8) - cnt_r);
  assign out_free  = !out_valid_r || out_ready;
  // load a new beat into the output register this cycle
  assign out_load  = out_free &&
                     ((state_r == S_DRAIN && cnt_r >= CNT_W'(8)) ||
                      (state_r == S_PAD && cnt_r != '0));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // dictionary write: clearing sweep or insert on a miss
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_r == S_CMP && !ram_rdata.valid) begin
      ram_we          = 1'b1;
      ram_waddr       = slot_r;
      ram_wdata.valid = 1'b1;
      ram_wdata.key   = key;
      ram_wdata.code  = next_r;
    end
  end

  lzwc_ram #(.DEPTH(HashSlots), .WIDTH(ENTRY_W)) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ret_r   <= S_IDLE;
      ret_r       <= S_IDLE;
      clr_addr_r  <= '0;
      pvalid_r    <= 1'b0;
      started_r   <= 1'b0;
      fin_r       <= 1'b0;
      prefix_r    <= '0;
      next_r      <= CODE_START;
      width_r     <= WIDTH_MIN;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + SLOT_W'(1);
          if (&clr_addr_r) begin
            state_r <= clr_ret_r;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            byte_r <= in_byte;
            last_r <= in_last;
            if (!started_r) begin
              // open the stream with a clear code
              started_r  <= 1'b1;
              put_code_r <= CODE_CLEAR;
              ret_r      <= S_LOOK;
              state_r    <= S_PUT;
            end else begin
              state_r <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (!pvalid_r) begin
            prefix_r <= CODE_W'(byte_r);
            pvalid_r <= 1'b1;
            state_r  <= S_TAIL;
          end else begin
            slot_r  <= prod[SLOT_W+6:7];
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          priority if (!ram_rdata.valid) begin
            // miss: emit prefix, pair inserted by the write port
            put_code_r <= prefix_r;
            ret_r      <= S_AFTER;
            state_r    <= S_PUT;
          end else if (ram_rdata.key == key) begin
            prefix_r <= ram_rdata.code;
            state_r  <= S_TAIL;
          end else begin
            slot_r  <= slot_r + SLOT_W'(1);
            state_r <= S_RD;
          end
        end
        S_AFTER: begin
          next_r <= next_inc[CODE_W-1:0];
          if (next_r == CODE_LIMIT) begin
            // table full: clear at current width, then restart
            put_code_r <= CODE_CLEAR;
            ret_r      <= S_RESTART;
            state_r    <= S_PUT;
          end else begin
            if ((next_inc >> width_r) != '0) begin
              width_r <= width_r + WID_W'(1);
            end
            prefix_r <= CODE_W'(byte_r);
            state_r  <= S_TAIL;
          end
        end
        S_RESTART: begin
          next_r     <= CODE_START;
          width_r    <= WIDTH_MIN;
          prefix_r   <= CODE_W'(byte_r);
          clr_addr_r <= '0;
          clr_ret_r  <= S_TAIL;
          state_r    <= S_CLEAR;
        end
        S_TAIL: begin
          if (last_r) begin
            put_code_r <= prefix_r;
            ret_r      <= S_END;
            state_r    <= S_PUT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_END: begin
          put_code_r <= CODE_END;
          fin_r      <= 1'b1;
          ret_r      <= S_PAD;
          state_r    <= S_PUT;
        end
        S_PAD: begin
          if (cnt_r == '0 || out_free) begin
            if (cnt_r != '0) begin
              out_byte_r  <= pad_word[7:0];
              out_last_r  <= 1'b1;
            end
            // end of stream: back to reset state, then sweep the table
            fin_r      <= 1'b0;
            pvalid_r   <= 1'b0;
            started_r  <= 1'b0;
            prefix_r   <= '0;
            next_r     <= CODE_START;
            width_r    <= WIDTH_MIN;
            acc_r      <= '0;
            cnt_r      <= '0;
            clr_addr_r <= '0;
            clr_ret_r  <= S_IDLE;
            state_r    <= S_CLEAR;
          end
        end
        S_PUT: begin
          acc_r   <= (acc_r << width_r) | ACC_W'(put_code_r & code_mask);
          cnt_r   <= cnt_r + CNT_W'(width_r);
          state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (cnt_r >= CNT_W'(8)) begin
            if (out_free) begin
              out_byte_r  <= drain_word[7:0];
              out_last_r  <= fin_r && (cnt_r == CNT_W'(8));
              cnt_r       <= cnt_r - CNT_W'(8);
            end
          end else begin
            state_r <= ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/lzwc_ram.sv @@
module lzwc_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ test/lzw_compressor_variable_width_tb.sv @@
`timescale 1ns / 100ps

module lzw_compressor_variable_width_tb;
  import lzwc_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;

  lzw_compressor_variable_width u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  // One packed output beat as the compressor should produce it.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } packed_beat_t;

  packed_beat_t packed_q[$];
  int unsigned  err_cnt;

  // Shadow compressor state. The dictionary is keyed by {prefix, byte}; the
  // hash layout of the block does not change which pairs are found.
  logic [CODE_W-1:0] code_dict[int unsigned];
  logic [CODE_W-1:0] cur_prefix;
  logic              have_prefix;
  int unsigned       nxt_code;
  int unsigned       cur_width;
  int unsigned       bit_acc;
  int unsigned       bit_cnt;
  logic              started;

  int unsigned burst_left;

  always #5 clk = ~clk;

  // Clear the shadow table, as after reset, table full or end of stream.
  function automatic void restart_table();
    code_dict.delete();
    nxt_code  = CODE_START;
    cur_width = MinCodeBits;
  endfunction

  // Append a code MSB first and push every completed byte.
  function automatic void pack_code(int unsigned code, int unsigned nbits);
    packed_beat_t pb;
    code    = code & ((1 << nbits) - 1);
    bit_acc = (bit_acc << nbits) | code;
    bit_cnt += nbits;
    while (bit_cnt >= 8) begin
      pb.data = 8'(bit_acc >> (bit_cnt - 8));
      pb.last = 1'b0;
      packed_q.push_back(pb);
      bit_cnt -= 8;
    end
    bit_acc &= (1 << bit_cnt) - 1;
  endfunction

  // Work out the packed bytes caused by one accepted input byte.
  function automatic void compress_byte(logic [7:0] b, logic last);
    int unsigned  key;
    packed_beat_t pb;
    if (!started) begin
      started = 1'b1;
      pack_code(CODE_CLEAR, cur_width);
    end
    if (!have_prefix) begin
      cur_prefix  = CODE_W'(b);
      have_prefix = 1'b1;
    end else begin
      key = (int'(cur_prefix) << 8) | b;
      if (code_dict.exists(key)) begin
        cur_prefix = code_dict[key];
      end else begin
        pack_code(cur_prefix, cur_width);
        code_dict[key] = CODE_W'(nxt_code);
        nxt_code++;
        // Table full: emit clear at the old width and start over.
        if (nxt_code == (1 << MaxCodeBits) - 2) begin
          pack_code(CODE_CLEAR, cur_width);
          restart_table();
        end
        if (nxt_code > (1 << cur_width) - 1) begin
          cur_width++;
          if (cur_width > MaxCodeBits) begin
            pack_code(CODE_CLEAR, cur_width);
            restart_table();
          end
        end
        cur_prefix = CODE_W'(b);
      end
    end
    if (last) begin
      pack_code(cur_prefix, cur_width);
      pack_code(CODE_END, cur_width);
      if (bit_cnt > 0) begin
        pb.data = 8'(bit_acc << (8 - bit_cnt));
        pb.last = 1'b0;
        packed_q.push_back(pb);
        bit_cnt = 0;
        bit_acc = 0;
      end
      // Mark the final byte of the compressed stream.
      packed_q[$].last = 1'b1;
      restart_table();
      cur_prefix  = '0;
      have_prefix = 1'b0;
      started     = 1'b0;
    end
  endfunction

  // Send one byte; the sender runs in bursts with random gaps between them.
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_byte  = b;
    in_last  = last;
    // Hold the beat until the block takes it.
    do @(posedge clk); while (!in_ready);
    compress_byte(b, last);
    @(negedge clk);
  endtask

  // Drop valid once a test has nothing more to send.
  task automatic go_idle();
    in_valid = 1'b0;
    in_last  = 1'b0;
  endtask

  task automatic test_directed();
    int i;
    // Shortest streams at the byte extremes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // A run of one value: dictionary hits build ever longer prefixes.
    for (i = 0; i < 9; i++) send_byte(8'hAA, i == 8);
    // Alternating bit patterns, ending on a hit.
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    go_idle();
  endtask

  // One stream of ascending bytes: every pair is new, so each byte inserts
  // and the width grows from 9 to 10 bits before the stream ends.
  task automatic test_width_growth();
    int i;
    for (i = 0; i < 256; i++) send_byte(8'(i), i == 255);
    go_idle();
  endtask

  // Short streams; most draw from a small alphabet so prefixes chain.
  task automatic test_random_streams();
    int sent;
    int len;
    int i;
    int alpha;
    logic [7:0] base;
    logic [7:0] b;
    sent = 0;
    while (sent < 30) begin
      len   = $urandom_range(1, 24);
      alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 4);
      base  = 8'($urandom);
      for (i = 0; i < len; i++) begin
        b = (alpha == 256) ? 8'($urandom) : base + 8'($urandom_range(0, alpha - 1));
        send_byte(b, i == len - 1);
      end
      sent += len;
    end
    go_idle();
  endtask

  // Receiver stall pattern: phases of full rate, random stalls and heavy
  // stalls, taken in turn.
  int unsigned rx_cyc;
  always @(negedge clk) begin
    rx_cyc <= rx_cyc + 1;
    case ((rx_cyc >> 6) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare every accepted output beat with the oldest expected one.
  initial begin
    packed_beat_t pb;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (packed_q.size() == 0) begin
          $error("unexpected beat: out_byte %02h out_last %0b", out_byte, out_last);
          err_cnt++;
        end else begin
          pb = packed_q.pop_front();
          if (out_byte !== pb.data) begin
            $error("out_byte: expected %02h, actual %02h", pb.data, out_byte);
            err_cnt++;
          end
          if (out_last !== pb.last) begin
            $error("out_last: expected %0b, actual %0b", pb.last, out_last);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = '0;
    in_last    = 1'b0;
    out_ready  = 1'b0;
    rx_cyc     = 0;
    err_cnt    = 0;
    burst_left = 0;
    restart_table();
    cur_prefix  = '0;
    have_prefix = 1'b0;
    bit_acc     = 0;
    bit_cnt     = 0;
    started     = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_width_growth();
    test_random_streams();

    // Drain, then let the last beats settle.
    while (packed_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (err_cnt == 0 && packed_q.size() == 0) begin
      $display("lzw_compressor_variable_width_tb: PASS");
    end else begin
      $display("lzw_compressor_variable_width_tb: FAIL");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #40ms;
    $display("lzw_compressor_variable_width_tb: FAIL");
    $finish;
  end

endmodule
